FILE: rtl/two_line_text_scroller_macros.svh
// assertion macros shared by the scroller rtl
// depends on nothing; included by files that carry assertions
`ifndef TWO_LINE_TEXT_SCROLLER_MACROS_SVH
`define TWO_LINE_TEXT_SCROLLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TLTS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define TLTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tlts_pkg.sv
// types and fixed constants of the two-line text scroller
// no dependencies; used by every rtl module of the block
`timescale 1ns / 1ps
package tlts_pkg;

   localparam int FUNC_W = 2;
   localparam int POS_W  = 6;
   localparam int CHAR_W = 8;
   localparam int LEN_W  = 6;
   localparam int KIND_W = 2;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE  = 2'd0,
      FUNC_COMMIT = 2'd1,
      FUNC_TICK   = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_CURSOR = 2'd1,
      KIND_DATA   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CURSOR,
      ST_DATA,
      ST_MOD
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              line_select;
      logic [POS_W-1:0]  position;
      logic [CHAR_W-1:0] character;
      logic [LEN_W-1:0]  text_length;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              cursor_line;
      logic [CHAR_W-1:0] glyph;
      logic              last_of_frame;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic              write;
      logic              commit;
      logic              clear_all;
      logic              serve;
      logic              emit;
      logic [KIND_W-1:0] kind;
      logic              line;
      logic              last;
      logic              idx_clr;
      logic              idx_inc;
      logic              rd_issue;
      logic              mod_start;
      logic              mod_commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] pend;
      logic       out_free;
      logic       line_long;
      logic       idx_last;
      logic       rem_busy;
   } status_type;

endpackage

FILE: rtl/tlts_rem.sv
// iterative remainder unit, one restoring step per cycle
// depends on tlts_pkg for the length width
`timescale 1ns / 1ps
module tlts_rem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tlts_pkg::LEN_W:0]   dividend,
   input  logic [tlts_pkg::LEN_W-1:0] divisor,
   output logic                       busy,
   output logic [tlts_pkg::LEN_W-1:0] remainder
);

   localparam int DVD_W = tlts_pkg::LEN_W + 1;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [DVD_W-1:0]           dvd_ff, dvd_in;
   logic [tlts_pkg::LEN_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0]           trial;

   assign busy      = (cnt_ff != '0);
   assign remainder = rem_ff;

   // partial remainder stays below divisor, so trial is below twice the divisor
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};

   always_comb begin
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      if (start) begin
         cnt_in = CNT_W'(DVD_W);
         dvd_in = dividend;
         rem_in = '0;
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = tlts_pkg::LEN_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[tlts_pkg::LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

endmodule

FILE: rtl/tlts_dp.sv
// datapath: text memory, line lengths, offsets, pending flags, output register
// depends on tlts_pkg, tlts_rem and the assertion macro header
`timescale 1ns / 1ps
`include "two_line_text_scroller_macros.svh"
module tlts_dp #(
   parameter int TEXT_CAPACITY = 64,
   parameter int DISPLAY_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tlts_pkg::req_type    req_data,
   input  tlts_pkg::cmd_type    cmd,
   output tlts_pkg::status_type status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output tlts_pkg::rsp_type    rsp_data
);

   localparam int AW    = $clog2(2 * TEXT_CAPACITY);
   localparam int IDX_W = $clog2(DISPLAY_WIDTH);
   localparam int WIN_W = $clog2((2 ** tlts_pkg::LEN_W) + DISPLAY_WIDTH);
   localparam int LW    = tlts_pkg::LEN_W;

   logic [tlts_pkg::CHAR_W-1:0] text_mem [2 * TEXT_CAPACITY];
   logic [tlts_pkg::CHAR_W-1:0] rd_data_ff;

   logic [LW-1:0]    len_ff [2];
   logic [LW-1:0]    len_in [2];
   logic [LW-1:0]    off_ff [2];
   logic [LW-1:0]    off_in [2];
   logic [1:0]       pend_ff, pend_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   tlts_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [LW-1:0]    cur_len;
   logic [LW-1:0]    start;
   logic [WIN_W-1:0] cur_pos;
   logic [WIN_W-1:0] rd_pos;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wr_addr;
   logic             wr_en;
   logic [LW-1:0]    len_sat;
   logic [tlts_pkg::CHAR_W-1:0] glyph;
   logic [LW:0]      dividend;
   logic [LW-1:0]    divisor;
   logic             rem_busy;
   logic [LW-1:0]    rem;
   logic             out_free;

   assign cur_len = len_ff[cmd.line];
   assign status.line_long = (int'(cur_len) > DISPLAY_WIDTH);
   assign start   = status.line_long ? off_ff[cmd.line] : '0;
   assign cur_pos = WIN_W'(start) + WIN_W'(idx_ff);

   // fetch runs one character ahead of the emitted one
   assign rd_pos  = cmd.idx_clr ? WIN_W'(start) : WIN_W'(start) + WIN_W'(idx_ff) + 1'b1;
   assign rd_en   = cmd.rd_issue && (int'(rd_pos) < TEXT_CAPACITY);
   assign rd_addr = AW'(cmd.line ? TEXT_CAPACITY : 0) + AW'(rd_pos);

   assign wr_en   = cmd.write && (int'(req_data.position) < TEXT_CAPACITY);
   assign wr_addr = AW'(req_data.line_select ? TEXT_CAPACITY : 0) + AW'(req_data.position);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         text_mem[wr_addr] <= req_data.character;
      end
      if (rd_en) begin
         rd_data_ff <= text_mem[rd_addr];
      end
   end

   assign len_sat = (int'(req_data.text_length) > TEXT_CAPACITY) ?
                    LW'(TEXT_CAPACITY) : req_data.text_length;

   // offset wrap: (offset + 1) mod (length - width + 1)
   assign dividend = {1'b0, off_ff[cmd.line]} + 1'b1;
   assign divisor  = LW'(int'(cur_len) - DISPLAY_WIDTH + 1);

   tlts_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .busy      (rem_busy),
      .remainder (rem)
   );

   always_comb begin
      len_in  = len_ff;
      off_in  = off_ff;
      pend_in = pend_ff;
      if (cmd.commit) begin
         len_in[req_data.line_select]  = len_sat;
         pend_in[req_data.line_select] = 1'b1;
      end
      if (cmd.clear_all) begin
         len_in[0] = '0;
         len_in[1] = '0;
         pend_in   = 2'b11;
      end
      if (cmd.serve) begin
         priority if (pend_ff[0]) begin
            pend_in[0] = 1'b0;
            off_in[0]  = '0;
         end else if (pend_ff[1]) begin
            pend_in[1] = 1'b0;
            off_in[1]  = '0;
         end
      end
      if (cmd.mod_commit) begin
         off_in[cmd.line] = rem;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // window positions past the length, and zero bytes, go out as spaces
   always_comb begin
      glyph = tlts_pkg::SPACE_CHAR;
      if ((cur_pos < WIN_W'(cur_len)) && (int'(cur_pos) < TEXT_CAPACITY) &&
          (rd_data_ff != '0)) begin
         glyph = rd_data_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.kind          = cmd.kind;
         rsp_data_in.cursor_line   = 1'b0;
         rsp_data_in.glyph         = '0;
         rsp_data_in.last_of_frame = 1'b0;
         if (cmd.kind != tlts_pkg::KIND_CLEAR) begin
            rsp_data_in.cursor_line = cmd.line;
         end
         if (cmd.kind == tlts_pkg::KIND_DATA) begin
            rsp_data_in.glyph         = glyph;
            rsp_data_in.last_of_frame = cmd.last;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff[0]    <= '0;
         len_ff[1]    <= '0;
         off_ff[0]    <= '0;
         off_ff[1]    <= '0;
         pend_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         off_ff       <= off_in;
         pend_ff      <= pend_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign status.pend     = pend_ff;
   assign status.out_free = out_free;
   assign status.idx_last = (idx_ff == IDX_W'(DISPLAY_WIDTH - 1));
   assign status.rem_busy = rem_busy;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TLTS_ASSERT_SAME(a_emit_slot_free, clock, reset, cmd.emit, out_free,
      "item loaded while output register still full")
   `TLTS_ASSERT_SAME(a_rem_idle_at_start, clock, reset, cmd.mod_start, !rem_busy,
      "remainder unit restarted while busy")
   `TLTS_ASSERT_SAME(a_rem_in_range, clock, reset, cmd.mod_commit, rem < divisor,
      "wrapped offset not below the wrap modulus")

endmodule

FILE: rtl/tlts_ctrl.sv
// controller: decodes items and sequences the clear, cursor, data and wrap steps
// depends on tlts_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "two_line_text_scroller_macros.svh"
module tlts_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [tlts_pkg::FUNC_W-1:0] req_func,
   input  tlts_pkg::status_type       status,
   output tlts_pkg::cmd_type          cmd
);

   tlts_pkg::state_type state_ff, state_in;
   logic                line_ff, line_in;
   logic                accept;

   assign accept = req_valid && (state_ff == tlts_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      line_in  = line_ff;
      unique case (state_ff)
         tlts_pkg::ST_IDLE: begin
            if (accept && (req_func == tlts_pkg::FUNC_TICK)) begin
               line_in  = 1'b0;
               state_in = (status.pend != 2'b00) ? tlts_pkg::ST_CLEAR : tlts_pkg::ST_CURSOR;
            end
         end
         tlts_pkg::ST_CLEAR: begin
            if (status.out_free) begin
               state_in = tlts_pkg::ST_CURSOR;
            end
         end
         tlts_pkg::ST_CURSOR: begin
            if (status.out_free) begin
               state_in = tlts_pkg::ST_DATA;
            end
         end
         tlts_pkg::ST_DATA: begin
            if (status.out_free && status.idx_last) begin
               priority if (status.line_long) begin
                  state_in = tlts_pkg::ST_MOD;
               end else if (!line_ff) begin
                  line_in  = 1'b1;
                  state_in = tlts_pkg::ST_CURSOR;
               end else begin
                  state_in = tlts_pkg::ST_IDLE;
               end
            end
         end
         tlts_pkg::ST_MOD: begin
            if (!status.rem_busy) begin
               if (!line_ff) begin
                  line_in  = 1'b1;
                  state_in = tlts_pkg::ST_CURSOR;
               end else begin
                  state_in = tlts_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = tlts_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cmd.line  = line_ff;
      cmd.kind  = tlts_pkg::KIND_DATA;
      unique case (state_ff)
         tlts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               cmd.write     = (req_func == tlts_pkg::FUNC_WRITE);
               cmd.commit    = (req_func == tlts_pkg::FUNC_COMMIT);
               cmd.clear_all = (req_func == tlts_pkg::FUNC_CLEAR);
            end
         end
         tlts_pkg::ST_CLEAR: begin
            cmd.kind = tlts_pkg::KIND_CLEAR;
            if (status.out_free) begin
               cmd.emit  = 1'b1;
               cmd.serve = 1'b1;
            end
         end
         tlts_pkg::ST_CURSOR: begin
            cmd.kind = tlts_pkg::KIND_CURSOR;
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.idx_clr  = 1'b1;
               cmd.rd_issue = 1'b1;
            end
         end
         tlts_pkg::ST_DATA: begin
            cmd.last = line_ff && status.idx_last;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.idx_last) begin
                  cmd.mod_start = status.line_long;
               end else begin
                  cmd.idx_inc  = 1'b1;
                  cmd.rd_issue = 1'b1;
               end
            end
         end
         tlts_pkg::ST_MOD: begin
            cmd.mod_commit = !status.rem_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlts_pkg::ST_IDLE;
         line_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         line_ff  <= line_in;
      end
   end

   `TLTS_ASSERT_NEXT(a_pending_tick_clears, clock, reset,
      accept && (req_func == tlts_pkg::FUNC_TICK) && (status.pend != 2'b00),
      state_ff == tlts_pkg::ST_CLEAR,
      "tick with a pending change did not start with a clear")
   `TLTS_ASSERT_SAME(a_wrap_only_long, clock, reset,
      state_ff == tlts_pkg::ST_MOD, status.line_long,
      "offset wrap on a line that fits the display")
   `TLTS_ASSERT_NEXT(a_line0_then_line1, clock, reset,
      (state_ff == tlts_pkg::ST_MOD) && !status.rem_busy && !line_ff,
      (state_ff == tlts_pkg::ST_CURSOR) && line_ff,
      "second line not drawn after first line wrap")

endmodule

FILE: rtl/two_line_text_scroller.sv
// top level of the two-line text scroller
// depends on tlts_pkg, tlts_ctrl, tlts_dp
//
//   channel | ports                      | moves
//   input   | req_valid/req_ready/req_data | one operation item (tlts_pkg::req_type)
//   result  | rsp_valid/rsp_ready/rsp_data | one display command item (tlts_pkg::rsp_type)
//
// write, commit and clear-both give no result.
// a tick emits a clear item on a pending change, then per line a cursor item and
// DISPLAY_WIDTH data items; wider lines add a wrap (7-step remainder unit and commit).
// results leave the output register at most one per cycle; text memory reads run one ahead.
// while the output register is full and not taken the sequencer holds its place.
// synchronous reset clears lengths, offsets and pending flags; the text memory is not reset.
`timescale 1ns / 1ps
module two_line_text_scroller #(
   parameter int TEXT_CAPACITY = 64,
   parameter int DISPLAY_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlts_pkg::rsp_type rsp_data
);

   tlts_pkg::cmd_type    cmd;
   tlts_pkg::status_type status;

   tlts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_data.func),
      .status    (status),
      .cmd       (cmd)
   );

   tlts_dp #(
      .TEXT_CAPACITY (TEXT_CAPACITY),
      .DISPLAY_WIDTH (DISPLAY_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
